### design/bfs_pkg.sv
// Shared constants, types and helper functions for the block frequency statistic.
package bfs_pkg;

  localparam int MAX_BLOCK_BITS_DEF = 1048576;
  localparam int MIN_BLOCK_BITS     = 8;

  localparam int BLOCK_LEN_W = 21;
  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST = 21'd128;

  localparam int SUM_W  = 53;
  localparam int BLK_W  = 32;
  localparam int DISC_W = 20;

  localparam int QUEUE_DEPTH = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 112;

  // Per-request control carried from the front end to the back end.
  typedef struct packed {
    logic close;  // a block completed within this byte
    logic last;   // final byte of the sequence: emit and clear
  } bfs_ctl_t;

  // Mask of the k lowest bits of a byte; k of eight or more gives all ones.
  function automatic logic [7:0] low_mask(input logic [3:0] k);
    logic [8:0] t;
    t = (9'h1 << k) - 9'h1;
    return t[7:0];
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

### design/bfs_front.sv
// Front end: bit and ones counters of the open block, block-close detection per byte.
module bfs_front import bfs_pkg::*; #(
  parameter int MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_BLOCK_BITS),
  localparam int OW    = $clog2(MAX_BLOCK_BITS) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic [3:0]             valid_bits,
  input  logic                   last_byte,
  input  logic [BLOCK_LEN_W-1:0] block_length,
  input  logic                   q_ready,
  output logic                   push,
  output bfs_ctl_t               push_ctl,
  output logic [OW-1:0]          push_ones,
  output logic [OW-1:0]          push_m,
  output logic [CNT_W-1:0]       push_disc
);

  logic [CNT_W-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0] ones_r, ones_nxt;
  logic [3:0]       nb;
  logic [OW-1:0]    m;
  logic [OW-1:0]    bits_ext;
  logic [OW-1:0]    need;
  logic [3:0]       need4;
  logic             close;
  logic [7:0]       mask_all;
  logic [7:0]       mask_head;
  logic [3:0]       head_ones;
  logic [3:0]       tail_ones;
  logic [3:0]       all_ones;
  logic             accept;

  assign accept   = in_valid && q_ready;
  assign in_ready = q_ready;

  always_comb begin
    nb = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
    if ({11'b0, block_length} < 32'(MIN_BLOCK_BITS)) begin
      m = OW'(MIN_BLOCK_BITS);
    end else if ({11'b0, block_length} > 32'(MAX_BLOCK_BITS)) begin
      m = OW'(MAX_BLOCK_BITS);
    end else begin
      m = OW'(block_length);
    end
  end

  // Bits still needed to close the open block; an overfull block closes on the next bit.
  assign bits_ext = OW'(bits_r);
  assign need     = (bits_ext >= m) ? OW'(1) : (m - bits_ext);
  assign close    = (need <= OW'(nb));
  assign need4    = need[3:0];

  assign mask_all  = low_mask(nb);
  assign mask_head = low_mask(need4);
  assign head_ones = popcnt8(data_byte & mask_head);
  assign tail_ones = popcnt8(data_byte & mask_all & ~mask_head);
  assign all_ones  = popcnt8(data_byte & mask_all);

  always_comb begin
    if (close) begin
      bits_nxt = CNT_W'(nb - need4);
      ones_nxt = CNT_W'(tail_ones);
    end else begin
      bits_nxt = bits_r + CNT_W'(nb);
      ones_nxt = ones_r + CNT_W'(all_ones);
    end
  end

  assign push           = accept && (close || last_byte);
  assign push_ctl.close = close;
  assign push_ctl.last  = last_byte;
  assign push_ones      = OW'(ones_r) + OW'(head_ones);
  assign push_m         = m;
  assign push_disc      = bits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      ones_r <= '0;
    end else if (accept) begin
      if (last_byte) begin
        bits_r <= '0;
        ones_r <= '0;
      end else begin
        bits_r <= bits_nxt;
        ones_r <= ones_nxt;
      end
    end
  end

endmodule

### design/bfs_queue.sv
// Short register FIFO decoupling the front end from the back end.
module bfs_queue import bfs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             in_ready,
  input  logic [WIDTH-1:0] wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             wr;
  logic             rd;

  assign in_ready  = (count_r != CNT_W'(DEPTH));
  assign out_valid = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign wr        = push && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(wr) - CNT_W'(rd);
    end
  end

endmodule

### design/bfs_back.sv
// Back end: deviation, square, saturating accumulation and the result register.
module bfs_back import bfs_pkg::*; #(
  parameter int MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_BLOCK_BITS),
  localparam int OW    = $clog2(MAX_BLOCK_BITS) + 1,
  localparam int DEV_W = OW + 1,
  localparam int SQ_W  = 2 * DEV_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  bfs_ctl_t          q_ctl,
  input  logic [OW-1:0]     q_ones,
  input  logic [OW-1:0]     q_m,
  input  logic [CNT_W-1:0]  q_disc,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SUM_W-1:0]  out_sum,
  output logic [BLK_W-1:0]  out_blocks,
  output logic [DISC_W-1:0] out_disc
);

  logic              adv;
  logic [DEV_W-1:0]  twice;
  logic [DEV_W-1:0]  m_ext;
  logic [DEV_W-1:0]  dev;

  logic              a_v_r;
  bfs_ctl_t          a_ctl_r;
  logic [DEV_W-1:0]  a_dev_r;
  logic [CNT_W-1:0]  a_disc_r;

  logic              b_v_r;
  bfs_ctl_t          b_ctl_r;
  logic [SQ_W-1:0]   b_sq_r;
  logic [CNT_W-1:0]  b_disc_r;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BLK_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W:0]    sum_add;

  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [BLK_W-1:0]  out_blocks_r;
  logic [DISC_W-1:0] out_disc_r;

  // Advance the whole pipe unless a finished result is still waiting.
  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;

  assign twice = {1'b0, q_ones} << 1;
  assign m_ext = DEV_W'(q_m);
  assign dev   = (twice >= m_ext) ? (twice - m_ext) : (m_ext - twice);

  assign sum_add = {1'b0, sum_r} + {1'b0, SUM_W'(b_sq_r)};

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (b_v_r && b_ctl_r.close) begin
      sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl_r  <= q_ctl;
      a_dev_r  <= dev;
      a_disc_r <= q_disc;
      b_ctl_r  <= a_ctl_r;
      b_sq_r   <= a_dev_r * a_dev_r;
      b_disc_r <= a_disc_r;
      if (b_v_r && b_ctl_r.last) begin
        out_sum_r    <= sum_nxt;
        out_blocks_r <= cnt_nxt;
        out_disc_r   <= DISC_W'(b_disc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= q_valid;
      b_v_r <= a_v_r;
      if (b_v_r && b_ctl_r.last) begin
        sum_r       <= '0;
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else begin
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sum    = out_sum_r;
  assign out_blocks = out_blocks_r;
  assign out_disc   = out_disc_r;

endmodule

### design/block_frequency_statistic.sv
// Top level of the block frequency statistic: front end, queue, back end, length register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tdata: data_byte, valid_bits; tlast: last_byte
//  out_     | master    | out_tvalid/out_tready| tdata: deviation_square_sum, full_blocks,
//           |           |                      |        discarded_bits
//  cfg_     | write     | cfg_wr_en            | cfg_wr_data: block_length
//
// One request is taken every cycle while the queue has room; the front end counts bits
// and ones of the open block combinationally from the byte popcount.
// After the edge that takes the last byte writes the queue entry, deviation, square and
// sum take one register each before out_tvalid rises.
// Reset (rst_n low, synchronous) clears all counters and sets the block length to 128.
// A result not taken holds the back end; in_tready drops once the four-entry queue is full.
module block_frequency_statistic import bfs_pkg::*; #(
  parameter int MAX_BLOCK_BITS = MAX_BLOCK_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte, [11:8] valid_bits
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [52:0] deviation_square_sum,
                                             // [84:53] full_blocks, [104:85] discarded_bits
  input  logic                   cfg_wr_en,
  input  logic [BLOCK_LEN_W-1:0] cfg_wr_data // block_length
);

  localparam int CNT_W = $clog2(MAX_BLOCK_BITS);
  localparam int OW    = $clog2(MAX_BLOCK_BITS) + 1;
  localparam int ENT_W = $bits(bfs_ctl_t) + OW + OW + CNT_W;

  logic [BLOCK_LEN_W-1:0] block_length_r;

  logic                   q_push;
  logic                   q_in_ready;
  bfs_ctl_t               push_ctl;
  logic [OW-1:0]          push_ones;
  logic [OW-1:0]          push_m;
  logic [CNT_W-1:0]       push_disc;

  logic                   q_out_valid;
  logic                   q_pop_ready;
  logic [ENT_W-1:0]       q_rdata;
  bfs_ctl_t               q_ctl;
  logic [OW-1:0]          q_ones;
  logic [OW-1:0]          q_m;
  logic [CNT_W-1:0]       q_disc;

  logic [SUM_W-1:0]       res_sum;
  logic [BLK_W-1:0]       res_blocks;
  logic [DISC_W-1:0]      res_disc;

  // Block length register: kept across sequences, set to 128 by reset, changed only by a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= BLOCK_LEN_RST;
    end else if (cfg_wr_en) begin
      block_length_r <= cfg_wr_data;
    end
  end

  bfs_front #(
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata[7:0]),
    .valid_bits  (in_tdata[11:8]),
    .last_byte   (in_tlast),
    .block_length(block_length_r),
    .q_ready     (q_in_ready),
    .push        (q_push),
    .push_ctl    (push_ctl),
    .push_ones   (push_ones),
    .push_m      (push_m),
    .push_disc   (push_disc)
  );

  // Hold only bytes that close a block or end the sequence.
  bfs_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .in_ready (q_in_ready),
    .wdata    ({push_ctl, push_ones, push_m, push_disc}),
    .out_valid(q_out_valid),
    .out_ready(q_pop_ready),
    .rdata    (q_rdata)
  );

  assign {q_ctl, q_ones, q_m, q_disc} = q_rdata;

  bfs_back #(
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_pop_ready),
    .q_ctl     (q_ctl),
    .q_ones    (q_ones),
    .q_m       (q_m),
    .q_disc    (q_disc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (res_sum),
    .out_blocks(res_blocks),
    .out_disc  (res_disc)
  );

  assign out_tdata = {7'b0, res_disc, res_blocks, res_sum};

`ifndef ASSERT_OFF
  // A final byte must always reach the queue, or its result is lost.
  a_last_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> q_push)
    else $error("last byte accepted without a queue entry");

  // The block length handed downstream is always clamped to the legal range.
  a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_m >= OW'(MIN_BLOCK_BITS) && push_m <= OW'(MAX_BLOCK_BITS)))
    else $error("block length out of range");

  // A waiting result stalls the back end, so nothing leaves the queue.
  a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !q_pop_ready)
    else $error("queue popped while a result waits");
`endif

endmodule

### bench/block_frequency_statistic_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the block frequency statistic: directed cases, random sequences.
module block_frequency_statistic_test;
  import bfs_pkg::*;

  // Quiet cycles tolerated before the run is declared hung. The longest honest gap is a
  // settle pause after a drain, a full sender gap or a full receiver stall.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to hold off after the last result before touching the length register:
  // the back-end pipeline stages plus a queue of four requests, with margin.
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 8;
  localparam int TARGET_ITEMS   = 650;
  localparam int VALID_FULL     = 8;
  localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned BLK_SAT = 64'hFFFF_FFFF;
  localparam logic [BLOCK_LEN_W-1:0] LEN_ALL_ONES = '1;

  // One expected statistic, as it leaves on the result channel.
  typedef struct {
    logic [SUM_W-1:0]  dev_sum;
    logic [BLK_W-1:0]  blocks;
    logic [DISC_W-1:0] tail_bits;
  } block_stat_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // [7:0] data_byte, [11:8] valid_bits
  logic                   in_tlast    = 1'b0; // last_byte
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [BLOCK_LEN_W-1:0] cfg_wr_data = BLOCK_LEN_RST;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [52:0] sum, [84:53] full_blocks, [104:85] discarded

  // Predictor: the length register and the open-sequence counters, kept wide enough that
  // a block never wraps before it closes.
  logic [BLOCK_LEN_W-1:0] model_len = BLOCK_LEN_RST;
  int unsigned            run_bits = 0;
  int unsigned            run_ones = 0;
  longint unsigned        run_sum = 0;
  longint unsigned        run_blocks = 0;
  block_stat_t            pending_stats[$];

  // Run bookkeeping.
  int  failures        = 0;
  int  requests_sent   = 0;
  int  stats_checked   = 0;
  int  length_writes   = 0;
  int  quiet_cycles    = 0;
  int  stall_left      = 0;
  bit  in_gaps_on      = 1'b1;
  bit  out_stalls_on   = 1'b1;

  block_frequency_statistic uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Block length actually in force: clamp the register to the supported range.
  function automatic int unsigned block_bits_in_force();
    int unsigned m;
    m = model_len;
    if (m < MIN_BLOCK_BITS) m = MIN_BLOCK_BITS;
    if (m > MAX_BLOCK_BITS_DEF) m = MAX_BLOCK_BITS_DEF;
    return m;
  endfunction

  // Advance the predictor by one accepted request; queue a statistic on the last byte.
  task automatic account_request(input logic [7:0] data, input logic [3:0] nbits,
                                 input logic last);
    int unsigned     m;
    int unsigned     n;
    int              i;
    longint unsigned twice;
    longint unsigned dev;
    block_stat_t     s;
    m = block_bits_in_force();
    n = (nbits > VALID_FULL) ? VALID_FULL : nbits;
    for (i = 0; i < n; i++) begin
      run_ones += data[i];
      run_bits++;
      // Close on reaching M; after a shrink of M the open block closes on its next bit.
      if (run_bits >= m) begin
        twice = 2 * longint'(run_ones);
        dev   = (twice >= m) ? twice - m : longint'(m) - twice;
        if (dev * dev > SUM_SAT - run_sum) run_sum = SUM_SAT;
        else run_sum += dev * dev;
        if (run_blocks != BLK_SAT) run_blocks++;
        run_bits = 0;
        run_ones = 0;
      end
    end
    if (last) begin
      s.dev_sum   = run_sum[SUM_W-1:0];
      s.blocks    = run_blocks[BLK_W-1:0];
      s.tail_bits = run_bits[DISC_W-1:0];
      pending_stats.push_back(s);
      run_bits   = 0;
      run_ones   = 0;
      run_sum    = 0;
      run_blocks = 0;
    end
  endtask

  // Offer one request after a random gap, hold it until taken, then predict it.
  task automatic send_request(input logic [7:0] data, input logic [3:0] nbits,
                              input logic last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({nbits, data});
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    account_request(data, nbits, last);
  endtask

  // Stop sending, wait for every outstanding statistic, then let the pipeline empty.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the block length; only ever done with the block idle.
  task automatic set_block_length(input logic [BLOCK_LEN_W-1:0] len);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_len = len;
    length_writes++;
  endtask

  task automatic record_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // Compare one result against the oldest expectation, field by field.
  task automatic check_stat(input logic [OUT_TDATA_W-1:0] word);
    block_stat_t       want;
    logic [SUM_W-1:0]  got_sum;
    logic [BLK_W-1:0]  got_blocks;
    logic [DISC_W-1:0] got_tail;
    got_sum    = word[SUM_W-1:0];
    got_blocks = word[SUM_W +: BLK_W];
    got_tail   = word[SUM_W+BLK_W +: DISC_W];
    if (pending_stats.size() == 0) begin
      record_failure($sformatf("result with nothing outstanding: sum %0d blocks %0d tail %0d",
                               got_sum, got_blocks, got_tail));
    end else begin
      want = pending_stats.pop_front();
      stats_checked++;
      if (got_sum !== want.dev_sum || got_blocks !== want.blocks ||
          got_tail !== want.tail_bits) begin
        record_failure($sformatf("sum exp %0d got %0d, blocks exp %0d got %0d, tail exp %0d got %0d",
                                 want.dev_sum, got_sum, want.blocks, got_blocks,
                                 want.tail_bits, got_tail));
      end
    end
  endtask

  // Result side: check each taken result, then drop ready for a random stall.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      check_stat(out_tdata);
      stall_left = out_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      out_tready <= (stall_left == 0);
    end else if (!out_tready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Reset length of 128: three bytes never close a block, so all 24 bits are discarded.
  task automatic test_default_length();
    send_request(8'hFF, 4'd8, 1'b0);
    send_request(8'h3C, 4'd8, 1'b0);
    send_request(8'h81, 4'd8, 1'b1);
  endtask

  // Extreme data, valid counts of zero, one, four, eight and above eight, and a last byte carrying no bits.
  task automatic test_field_extremes();
    set_block_length(BLOCK_LEN_W'(MIN_BLOCK_BITS));
    send_request(8'hFF, 4'd8, 1'b0);
    send_request(8'h00, 4'd8, 1'b0);
    send_request(8'hA5, 4'd15, 1'b0);
    send_request(8'h5A, 4'd9, 1'b0);
    send_request(8'hFF, 4'd0, 1'b0);
    send_request(8'h01, 4'd1, 1'b0);
    send_request(8'h80, 4'd4, 1'b1);
    send_request(8'hFF, 4'd0, 1'b1);
  endtask

  // Lengths below the minimum and above the maximum act as the nearest limit.
  task automatic test_length_clamp();
    set_block_length('0);
    send_request(8'hF0, 4'd8, 1'b1);
    set_block_length(BLOCK_LEN_W'(MIN_BLOCK_BITS - 1));
    send_request(8'hFF, 4'd7, 1'b0);
    send_request(8'hFF, 4'd8, 1'b1);
    set_block_length(LEN_ALL_ONES);
    send_request(8'hFF, 4'd8, 1'b0);
    send_request(8'h55, 4'd8, 1'b1);
    set_block_length(BLOCK_LEN_W'(MAX_BLOCK_BITS_DEF));
    send_request(8'h00, 4'd3, 1'b1);
  endtask

  // Shrink M below the bits already held (closes on the next bit), then grow it mid-block.
  task automatic test_length_change_mid_block();
    set_block_length(BLOCK_LEN_W'(64));
    repeat (5) send_request(8'hFF, 4'd8, 1'b0);
    set_block_length(BLOCK_LEN_W'(16));
    send_request(8'h0F, 4'd8, 1'b0);
    send_request(8'h00, 4'd8, 1'b1);
    set_block_length(BLOCK_LEN_W'(8));
    send_request(8'hC3, 4'd6, 1'b0);
    set_block_length(BLOCK_LEN_W'(40));
    send_request(8'hFF, 4'd8, 1'b0);
    send_request(8'hFF, 4'd8, 1'b1);
  endtask

  // Back-to-back one-byte sequences against a stalling receiver: fill the queue so that
  // in_tready drops, then hold the sender until every statistic is back.
  task automatic test_backpressure();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b1;
    repeat (20) send_request(8'($urandom), 4'($urandom_range(0, 15)), 1'b1);
    drain_pipeline();
    in_gaps_on = 1'b1;
  endtask

  // Random sequences in batches that share one idling mode and, but for an occasional mid-block change, one length.
  task automatic test_random_sequences();
    int unsigned pick;
    int unsigned len;
    int unsigned nbytes;
    int unsigned style;
    int          nseq;
    int          seq;
    int          k;
    logic [7:0]  data;
    logic [3:0]  nbits;
    while (requests_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 3);
      in_gaps_on    = pick[0];
      out_stalls_on = pick[1];
      pick = $urandom_range(0, 15);
      if (pick < 9) len = $urandom_range(8, 40);
      else if (pick < 11) len = $urandom_range(0, 7);
      else if (pick < 14) len = $urandom_range(41, 200);
      else if (pick < 15) len = 512;
      else len = $urandom_range(MAX_BLOCK_BITS_DEF + 1, (1 << BLOCK_LEN_W) - 1);
      set_block_length(BLOCK_LEN_W'(len));
      nseq = $urandom_range(2, 5);
      for (seq = 0; seq < nseq && requests_sent < TARGET_ITEMS; seq++) begin
        if (len == 512) nbytes = $urandom_range(64, 150);
        else if ($urandom_range(0, 15) == 0) nbytes = 1;
        else nbytes = $urandom_range(1, 48);
        style = $urandom_range(0, 3);
        for (k = 0; k < nbytes; k++) begin
          case (style)
            0: data = 8'($urandom);
            1: data = 8'($urandom | $urandom);
            2: data = 8'($urandom & $urandom);
            default: data = (k % 2 == 0) ? 8'hFF : 8'h00;
          endcase
          nbits = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'(VALID_FULL);
          // Now and then move the length inside an open block.
          if (k == nbytes / 2 && nbytes > 4 && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(8, 40);
            set_block_length(BLOCK_LEN_W'(len));
          end
          send_request(data, nbits, k == nbytes - 1);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_length();
    test_field_extremes();
    test_length_clamp();
    test_length_change_mid_block();
    test_backpressure();
    test_random_sequences();
    drain_pipeline();
    $display("covered %0d requests, %0d statistics checked, %0d length writes",
             requests_sent, stats_checked, length_writes);
    $display("lengths clamped low and high, mid-block length changes, valid counts 0 to 15");
    if (failures == 0 && pending_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d statistics outstanding", failures, pending_stats.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/bfs_pkg.sv
design/bfs_front.sv
design/bfs_queue.sv
design/bfs_back.sv
design/block_frequency_statistic.sv
bench/block_frequency_statistic_test.sv
